### rtl/core/tsm_pkg.sv
// Shared types and constants for the threshold-triggered sample mixer.
`timescale 1ns / 1ps
package tsm_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int ADDR_W    = 16;
   localparam int THRESH_W  = 15;
   localparam int DIVISOR_W = 8;
   localparam int END_W     = 17;
   localparam int INDEX_W   = 17;
   localparam int CSR_AW    = 4;
   localparam int CSR_DW    = 32;

   localparam logic [THRESH_W-1:0]  THRESHOLD_RESET = 15'd10292;
   localparam logic [DIVISOR_W-1:0] DIVISOR_RESET   = 8'd3;
   localparam logic [END_W-1:0]     END_RESET       = 17'd65536;

   // register index, taken from paddr[3:2]
   localparam logic [1:0] CSR_THRESHOLD  = 2'd0;
   localparam logic [1:0] CSR_DIVISOR    = 2'd1;
   localparam logic [1:0] CSR_SAMPLE_END = 2'd2;

   localparam logic OP_AUDIO = 1'b0;
   localparam logic OP_LOAD  = 1'b1;

   // one classified item as it travels from front to back
   typedef struct packed {
      logic                is_load;
      logic                trigger;
      logic [SAMPLE_W-1:0] value;
      logic [ADDR_W-1:0]   addr;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_PREP,
      ST_DIV,
      ST_DONE
   } back_state_type;

endpackage

### rtl/core/tsm_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module tsm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/tsm_front.sv
// Front end: accepts items and flags audio that crosses the threshold.
`timescale 1ns / 1ps
module tsm_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic                          opcode,
   input  logic [tsm_pkg::SAMPLE_W-1:0]  sample_value,
   input  logic [tsm_pkg::ADDR_W-1:0]    store_address,
   input  logic [tsm_pkg::THRESH_W-1:0]  threshold,
   input  logic                          q_full,
   output logic                          q_push,
   output tsm_pkg::item_type             q_item
);
   import tsm_pkg::*;

   logic                valid_ff, valid_in;
   item_type            item_ff, item_in;
   logic [SAMPLE_W:0]   magnitude;
   logic                accept;

   // |audio| in 17 bits so that -32768 stays exact
   always_comb begin
      if (sample_value[SAMPLE_W-1]) begin
         magnitude = -{sample_value[SAMPLE_W-1], sample_value};
      end else begin
         magnitude = {1'b0, sample_value};
      end
   end

   assign q_push = valid_ff && !q_full;
   assign full   = valid_ff && q_full;
   assign accept = push && !full;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (q_push) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in        = 1'b1;
         item_in.is_load = (opcode == OP_LOAD);
         item_in.trigger = magnitude > {2'b00, threshold};
         item_in.value   = sample_value;
         item_in.addr    = store_address;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign q_item = item_ff;

endmodule

### rtl/core/tsm_queue.sv
// Two-entry queue between front end and back end.
`timescale 1ns / 1ps
module tsm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tsm_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output tsm_pkg::item_type head,
   output logic              empty
);
   import tsm_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/core/tsm_back.sv
// Back end: sample store, playback sequencing, serial divide and result register.
`timescale 1ns / 1ps
module tsm_back #(
   parameter int STORE_DEPTH = 65536
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tsm_pkg::item_type              head,
   input  logic                           q_empty,
   output logic                           q_pop,
   input  logic [tsm_pkg::DIVISOR_W-1:0]  blend_divisor,
   input  logic [tsm_pkg::END_W-1:0]      sample_end,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [tsm_pkg::SAMPLE_W-1:0]   rsp_mixed_sample,
   output logic                           rsp_playing
);
   import tsm_pkg::*;

   localparam int          AW      = $clog2(STORE_DEPTH);
   localparam logic [31:0] DEPTH_W = 32'(STORE_DEPTH);

   back_state_type         state_ff, state_in;
   logic [INDEX_W-1:0]     index_ff, index_in;
   logic [SAMPLE_W-1:0]    held_ff, held_in;
   logic [SAMPLE_W-1:0]    audio_ff, audio_in;
   logic                   neg_ff, neg_in;
   logic [DIVISOR_W-1:0]   rem_ff, rem_in;
   logic [SAMPLE_W-1:0]    quo_ff, quo_in;
   logic [3:0]             count_ff, count_in;
   logic                   out_valid_ff, out_valid_in;
   logic [SAMPLE_W-1:0]    mixed_ff, mixed_in;
   logic                   playing_ff, playing_in;

   logic                   ram_we;
   logic [SAMPLE_W-1:0]    ram_rdata;
   logic [31:0]            waddr_w, raddr_w;
   logic                   load_in_range, index_in_store, index_below_end;
   logic                   play;
   logic [DIVISOR_W-1:0]   divisor;
   logic [DIVISOR_W:0]     trial;
   logic                   trial_ge;
   logic [SAMPLE_W-1:0]    quotient;
   logic                   out_load;

   assign waddr_w         = 32'(head.addr);
   assign raddr_w         = 32'(index_ff);
   assign load_in_range   = waddr_w < DEPTH_W;
   assign index_in_store  = raddr_w < DEPTH_W;
   assign index_below_end = index_ff < sample_end;
   assign play            = head.trigger || (index_ff != '0);
   assign divisor         = (blend_divisor == '0) ? DIVISOR_W'(1) : blend_divisor;
   assign trial           = {rem_ff, quo_ff[SAMPLE_W-1]};
   assign trial_ge        = trial >= {1'b0, divisor};
   assign quotient        = neg_ff ? -quo_ff : quo_ff;

   tsm_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (waddr_w[AW-1:0]),
      .wdata (head.value),
      .raddr (raddr_w[AW-1:0]),
      .rdata (ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty && !head.is_load) begin
               if (play && index_below_end && index_in_store) begin
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_PREP;
               end
            end
         end
         ST_FETCH: state_in = ST_PREP;
         ST_PREP:  state_in = ST_DIV;
         ST_DIV: begin
            if (count_ff == 4'd15) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      q_pop      = 1'b0;
      ram_we     = 1'b0;
      out_load   = 1'b0;
      index_in   = index_ff;
      held_in    = held_ff;
      audio_in   = audio_ff;
      neg_in     = neg_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      count_in   = count_ff;
      mixed_in   = mixed_ff;
      playing_in = playing_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (head.is_load) begin
                  ram_we = load_in_range;
               end else begin
                  audio_in = head.value;
                  if (play) begin
                     if (index_below_end) begin
                        index_in = index_ff + INDEX_W'(1);
                        if (!index_in_store) begin
                           held_in = '0;
                        end
                     end else begin
                        held_in  = '0;
                        index_in = '0;
                     end
                  end
               end
            end
         end
         ST_FETCH: held_in = ram_rdata;
         ST_PREP: begin
            neg_in   = held_ff[SAMPLE_W-1];
            quo_in   = held_ff[SAMPLE_W-1] ? -held_ff : held_ff;
            rem_in   = '0;
            count_in = '0;
         end
         ST_DIV: begin
            // restoring divide, one quotient bit a cycle
            rem_in   = trial_ge ? DIVISOR_W'(trial - {1'b0, divisor})
                                : trial[DIVISOR_W-1:0];
            quo_in   = {quo_ff[SAMPLE_W-2:0], trial_ge};
            count_in = count_ff + 4'd1;
         end
         ST_DONE: begin
            out_load = !out_valid_ff || rsp_pop;
            if (out_load) begin
               held_in    = quotient;
               mixed_in   = audio_ff + quotient;
               playing_in = (index_ff != '0);
            end
         end
         default: ;
      endcase
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         index_ff     <= '0;
         held_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         index_ff     <= index_in;
         held_ff      <= held_in;
         out_valid_ff <= out_valid_in;
      end
      audio_ff   <= audio_in;
      neg_ff     <= neg_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      count_ff   <= count_in;
      mixed_ff   <= mixed_in;
      playing_ff <= playing_in;
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_mixed_sample = mixed_ff;
   assign rsp_playing      = playing_ff;

endmodule

### rtl/core/threshold_triggered_sample_mixer_unit.sv
// Top level of the threshold-triggered sample mixer.
`timescale 1ns / 1ps
// Usage
//   Input queue (req_*): push an item while req_full is low. opcode 1 writes
//   req_sample_value into the sample store at req_store_address (addresses at
//   or above STORE_DEPTH are dropped) and gives no result. opcode 0 is an audio
//   sample; it gives exactly one result.
//   Result queue (rsp_*): the oldest result sits on rsp_mixed_sample and
//   rsp_playing while rsp_empty is low; rsp_pop takes it.
//   CSR port: threshold at 0x0, blend divisor at 0x4, sample end at 0x8.
//   Write only while the block is idle.
// Sequencing
//   A load item is written to the store in the decide step alone. An audio
//   item passes decide, store read (only when it reads a store word), sign
//   prep, 16 divide steps and result write; the serial divider sets the rate.
//   With the queues empty an input passes the front register and a queue
//   entry before the back end takes it. While the back end works the front
//   stage and a two-entry queue keep taking items; an unpopped result stalls
//   the back end and the input side then fills up and raises req_full.
// Reset
//   Synchronous; clears playback, held value and queues and resets the CSRs.
//   The sample store is not cleared: load it before playback.
module threshold_triggered_sample_mixer_unit #(
   parameter int STORE_DEPTH = 65536
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic                           req_opcode,
   input  logic signed [tsm_pkg::SAMPLE_W-1:0] req_sample_value,
   input  logic [tsm_pkg::ADDR_W-1:0]     req_store_address,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic signed [tsm_pkg::SAMPLE_W-1:0] rsp_mixed_sample,
   output logic                           rsp_playing,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [tsm_pkg::CSR_AW-1:0]     csr_paddr,
   input  logic [tsm_pkg::CSR_DW-1:0]     csr_pwdata,
   output logic [tsm_pkg::CSR_DW-1:0]     csr_prdata,
   output logic                           csr_pready
);
   import tsm_pkg::*;

   logic [THRESH_W-1:0]  threshold_ff, threshold_in;
   logic [DIVISOR_W-1:0] divisor_ff, divisor_in;
   logic [END_W-1:0]     sample_end_ff, sample_end_in;
   logic                 csr_write;
   logic [1:0]           csr_index;

   logic                 q_push, q_full, q_pop, q_empty;
   item_type             q_item, q_head;
   logic [SAMPLE_W-1:0]  mixed;

   // ---- CSR block: zero wait state, written in the access phase ----
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      threshold_in  = threshold_ff;
      divisor_in    = divisor_ff;
      sample_end_in = sample_end_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_THRESHOLD:  threshold_in  = csr_pwdata[THRESH_W-1:0];
            CSR_DIVISOR:    divisor_in    = csr_pwdata[DIVISOR_W-1:0];
            CSR_SAMPLE_END: sample_end_in = csr_pwdata[END_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_THRESHOLD:  csr_prdata = CSR_DW'(threshold_ff);
         CSR_DIVISOR:    csr_prdata = CSR_DW'(divisor_ff);
         CSR_SAMPLE_END: csr_prdata = CSR_DW'(sample_end_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= THRESHOLD_RESET;
         divisor_ff    <= DIVISOR_RESET;
         sample_end_ff <= END_RESET;
      end else begin
         threshold_ff  <= threshold_in;
         divisor_ff    <= divisor_in;
         sample_end_ff <= sample_end_in;
      end
   end

   // ---- front: accept and classify ----
   tsm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (req_push),
      .full          (req_full),
      .opcode        (req_opcode),
      .sample_value  (req_sample_value),
      .store_address (req_store_address),
      .threshold     (threshold_ff),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_item        (q_item)
   );

   // ---- decoupling queue ----
   tsm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   // ---- back: store, playback, divide, result register ----
   tsm_back #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (q_head),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .blend_divisor    (divisor_ff),
      .sample_end       (sample_end_ff),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_mixed_sample (mixed),
      .rsp_playing      (rsp_playing)
   );

   assign rsp_mixed_sample = mixed;

endmodule

### tb/tsm_checker.sv
// Passive checker: predicts each mixed sample and compares the result queue.
`timescale 1ns / 1ps
module tsm_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   input  logic                                req_full,
   input  logic                                req_opcode,
   input  logic signed [tsm_pkg::SAMPLE_W-1:0] req_sample_value,
   input  logic [tsm_pkg::ADDR_W-1:0]          req_store_address,
   input  logic                                rsp_empty,
   input  logic                                rsp_pop,
   input  logic signed [tsm_pkg::SAMPLE_W-1:0] rsp_mixed_sample,
   input  logic                                rsp_playing,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic                                csr_pready,
   input  logic [tsm_pkg::CSR_AW-1:0]          csr_paddr,
   input  logic [tsm_pkg::CSR_DW-1:0]          csr_pwdata,
   output int                                  error_count,
   output int                                  pending_count
);
   import tsm_pkg::*;

   localparam int STORE_WORDS = 65536;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [SAMPLE_W-1:0] mixed;
      logic                playing;
   } mix_result_type;

   mix_result_type mix_expect_q[$];

   // shadow of the block's state and registers
   logic [SAMPLE_W-1:0]        store_mem [0:STORE_WORDS-1];
   logic [INDEX_W-1:0]         play_pos;
   logic signed [SAMPLE_W-1:0] held_val;
   logic [THRESH_W-1:0]        thr_q;
   logic [DIVISOR_W-1:0]       div_q;
   logic [END_W-1:0]           end_q;
   int                         fail_total;

   function automatic mix_result_type mix_audio(input logic signed [SAMPLE_W-1:0] audio);
      int             lvl;
      int             lim;
      int             acc;
      int             dv;
      mix_result_type res;
      lvl = audio;
      lim = thr_q;
      if (lvl > lim || lvl < -lim || play_pos != '0) begin
         if (play_pos < end_q) begin
            // reads past the store give zero
            held_val = (play_pos < STORE_WORDS) ? store_mem[play_pos[ADDR_W-1:0]] : '0;
            play_pos = play_pos + 1'b1;
         end else begin
            held_val = '0;
            play_pos = '0;
         end
      end
      // divisor 0 behaves as 1; int division truncates toward zero
      dv = (div_q == '0) ? 1 : int'(div_q);
      acc = held_val;
      acc = acc / dv;
      held_val = acc[SAMPLE_W-1:0];
      res.mixed = audio + held_val;
      res.playing = (play_pos != '0);
      return res;
   endfunction

   always @(posedge clock) begin
      mix_result_type got_res;
      mix_result_type want_res;
      if (reset) begin
         play_pos = '0;
         held_val = '0;
         thr_q = THRESHOLD_RESET;
         div_q = DIVISOR_RESET;
         end_q = END_RESET;
         fail_total = 0;
         mix_expect_q.delete();
      end else begin
         if (!rsp_empty && rsp_pop) begin
            got_res.mixed = rsp_mixed_sample;
            got_res.playing = rsp_playing;
            if (mix_expect_q.size() == 0) begin
               fail_total++;
               if (fail_total <= REPORT_LIMIT)
                  $display("%t: result with nothing expected: mixed %0d playing %0b",
                           $time, $signed(got_res.mixed), got_res.playing);
            end else begin
               want_res = mix_expect_q.pop_front();
               if (got_res.mixed !== want_res.mixed || got_res.playing !== want_res.playing)
               begin
                  fail_total++;
                  if (fail_total <= REPORT_LIMIT)
                     $display("%t: mismatch: mixed exp %0d got %0d, playing exp %0b got %0b",
                              $time, $signed(want_res.mixed), $signed(got_res.mixed),
                              want_res.playing, got_res.playing);
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               CSR_THRESHOLD:  thr_q = csr_pwdata[THRESH_W-1:0];
               CSR_DIVISOR:    div_q = csr_pwdata[DIVISOR_W-1:0];
               CSR_SAMPLE_END: end_q = csr_pwdata[END_W-1:0];
               default: ;
            endcase
         end
         if (req_push && !req_full) begin
            if (req_opcode == OP_LOAD)
               store_mem[req_store_address] = req_sample_value;
            else
               mix_expect_q.push_back(mix_audio(req_sample_value));
         end
      end
      error_count <= fail_total;
      pending_count <= mix_expect_q.size();
   end

endmodule

### tb/tb.sv
// Testbench top: drives the sample mixer and reports the verdict.
`timescale 1ns / 1ps
module tb;
   import tsm_pkg::*;

   // Store words 0..PREFIX_WORDS-1 are loaded before any audio. Normal phases
   // keep sample_end at 48 or below, and the long-end phases carry at most 40
   // items, so playback never reads a word that was never loaded.
   localparam int PREFIX_WORDS  = 96;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 30;
   localparam int PHASES        = 8;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_push = 1'b0;
   logic                       req_full;
   logic                       req_opcode = OP_AUDIO;
   logic signed [SAMPLE_W-1:0] req_sample_value = '0;
   logic [ADDR_W-1:0]          req_store_address = '0;
   logic                       rsp_empty;
   logic                       rsp_pop = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_mixed_sample;
   logic                       rsp_playing;
   logic                       csr_psel = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]          csr_paddr = '0;
   logic [CSR_DW-1:0]          csr_pwdata = '0;
   logic [CSR_DW-1:0]          csr_prdata;
   logic                       csr_pready;

   int error_count;
   int pending_count;

   // idling controls: gap_pct is only used by the stimulus process,
   // stall_pct is read by the receiver process
   int   gap_pct = 0;
   int   stall_pct = 0;
   logic long_hold_go = 1'b0;
   logic long_hold_started = 1'b0;
   int   hold_left = 0;

   logic [THRESH_W-1:0] cur_thr = THRESHOLD_RESET;

   threshold_triggered_sample_mixer_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_opcode        (req_opcode),
      .req_sample_value  (req_sample_value),
      .req_store_address (req_store_address),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_mixed_sample  (rsp_mixed_sample),
      .rsp_playing       (rsp_playing),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   tsm_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_opcode        (req_opcode),
      .req_sample_value  (req_sample_value),
      .req_store_address (req_store_address),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_mixed_sample  (rsp_mixed_sample),
      .rsp_playing       (rsp_playing),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_pready        (csr_pready),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .error_count       (error_count),
      .pending_count     (pending_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #3_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Receiver: random stalls per phase, plus one long hold-off so the
   // block backs up and raises req_full while the sender keeps pushing.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (long_hold_go && !long_hold_started) begin
         long_hold_started <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Offer one item and hold it until the transfer. req_push stays high on
   // return so back-to-back items need no low cycle in between.
   task automatic send_item(input logic op, input logic [SAMPLE_W-1:0] value,
                            input logic [ADDR_W-1:0] addr);
      while ($urandom_range(99) < gap_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_opcode <= op;
      req_sample_value <= value;
      req_store_address <= addr;
      forever begin
         @(posedge clock);
         if (!req_full) break;
      end
   endtask

   // Wait for every result to come back, then let any trailing load items
   // drain out of the pipe before touching the registers.
   task automatic wait_drained();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [CSR_DW-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      // register takes the write at this edge
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input int thr, input int div, input int end_words);
      csr_write(CSR_THRESHOLD, CSR_DW'(thr));
      csr_write(CSR_DIVISOR, CSR_DW'(div));
      csr_write(CSR_SAMPLE_END, CSR_DW'(end_words));
      cur_thr = THRESH_W'(thr);
   endtask

   // Audio level: half quiet levels at or below the threshold, some right
   // at the threshold edge, some anywhere in range (hits start playback).
   function automatic logic [SAMPLE_W-1:0] random_audio();
      int kind;
      int mag;
      kind = $urandom_range(9);
      if (kind < 3)
         return SAMPLE_W'($urandom);
      if (kind < 5)
         mag = int'(cur_thr) - 1 + int'($urandom_range(2));
      else
         mag = $urandom_range(cur_thr);
      return SAMPLE_W'($urandom_range(1) ? -mag : mag);
   endfunction

   initial begin
      int n_items;
      int thr;
      int div;
      int end_words;
      int mode;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Load the playback prefix; the first words are the extreme values.
      send_item(OP_LOAD, 16'h7FFF, 16'd0);
      send_item(OP_LOAD, 16'h8000, 16'd1);
      send_item(OP_LOAD, 16'hFFFF, 16'd2);
      send_item(OP_LOAD, 16'h0001, 16'd3);
      for (int i = 4; i < PREFIX_WORDS; i++)
         send_item(OP_LOAD, SAMPLE_W'($urandom), ADDR_W'(i));

      // Directed part under reset settings (threshold 10292, divisor 3,
      // end 65536).
      send_item(OP_AUDIO, 16'h0000, 16'd0);     // silence, nothing held
      send_item(OP_AUDIO, 16'sd10292, 16'd0);   // equal to threshold: no trigger
      send_item(OP_AUDIO, -16'sd10292, 16'd0);  // equal to -threshold: no trigger
      send_item(OP_LOAD, 16'h8000, 16'hFFFF);   // top store address
      send_item(OP_AUDIO, -16'sd10293, 16'd0);  // just past: starts on max word
      send_item(OP_AUDIO, 16'h7FFF, 16'd0);     // min word held
      send_item(OP_AUDIO, 16'h8000, 16'd0);     // -1 word divides to zero
      send_item(OP_LOAD, 16'h7FFF, 16'd5);      // loads do not disturb playback
      send_item(OP_LOAD, 16'h8000, 16'd6);
      send_item(OP_AUDIO, 16'h0000, 16'hFFFF);
      send_item(OP_AUDIO, 16'h0000, 16'd0);
      send_item(OP_AUDIO, 16'h7FFF, 16'd0);     // positive wrap
      send_item(OP_AUDIO, 16'h8000, 16'd0);     // negative wrap
      send_item(OP_AUDIO, 16'sd10293, 16'd0);   // retrigger while playing
      send_item(OP_AUDIO, 16'hFFFF, 16'd0);
      send_item(OP_AUDIO, 16'h0001, 16'd0);
      send_item(OP_LOAD, 16'h0000, 16'h8000);
      send_item(OP_AUDIO, 16'h0000, 16'd0);
      req_push <= 1'b0;

      // Random phases: each sets the registers, then runs a burst under one
      // idling mode. Phase 0 also carries the long receiver hold-off.
      for (int ph = 0; ph < PHASES; ph++) begin
         wait_drained();
         case (ph)
            0: begin thr = 0; div = 0; end_words = 0; end
            1: begin thr = 32767; div = 1; end_words = 1; end
            2: begin
               thr = $urandom_range(32767);
               div = 255;
               end_words = 48;
            end
            3: begin
               thr = $urandom_range(3000);
               div = $urandom_range(255, 1);
               end_words = $urandom_range(48, 2);
            end
            4: begin
               thr = $urandom_range(3000);
               div = $urandom_range(16, 1);
               end_words = 65536;
            end
            5: begin
               thr = $urandom_range(32767);
               div = $urandom_range(255);
               end_words = $urandom_range(48, 1);
            end
            6: begin
               thr = $urandom_range(1500);
               div = $urandom_range(4, 1);
               end_words = $urandom_range(48, 8);
            end
            default: begin
               thr = $urandom_range(3000);
               div = $urandom_range(255, 1);
               end_words = 131071;
            end
         endcase
         configure(thr, div, end_words);

         mode = ph % 4;
         gap_pct = (mode == 1) ? 86 : (mode == 3) ? 38 : 0;
         stall_pct <= (mode == 2) ? 86 : (mode == 3) ? 38 : 0;
         // long-end phases stay short so playback stays inside the prefix
         n_items = (end_words > 48) ? 40 : 46;

         for (int k = 0; k < n_items; k++) begin
            if (ph == 0 && k == 10)
               long_hold_go <= 1'b1;
            if ($urandom_range(99) < 30)
               send_item(OP_LOAD, SAMPLE_W'($urandom),
                         ($urandom_range(99) < 85)
                            ? ADDR_W'($urandom_range(PREFIX_WORDS - 1))
                            : ADDR_W'($urandom));
            else
               send_item(OP_AUDIO, random_audio(), ADDR_W'($urandom));
         end
         req_push <= 1'b0;
      end

      wait_drained();
      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
